/* rtl/sip_pkg.sv */
// Package with the widths, request and result types of the segment intersection block.
`timescale 1ns / 1ps
package sip_pkg;

  localparam int CW   = 24;             // coordinate width
  localparam int DW   = CW + 1;         // width of a coordinate difference
  localparam int PW   = 2 * DW;         // width of one signed product
  localparam int XW   = PW + 1;         // width of a cross product
  localparam int MW   = CW;             // magnitude of a difference, also quotient width
  localparam int NW   = 2 * CW + 1;     // magnitude of the denominator
  localparam int NLO  = (NW + 1) / 2;   // low slice of the numerator
  localparam int NHI  = NW - NLO;       // high slice of the numerator
  localparam int QPW  = MW + NW;        // width of the scaled dividend
  localparam int CLAT = 4;              // stages of the classifier
  localparam int DLAT = MW + 2;         // stages of one divider lane
  localparam int SBD  = 2 + DLAT;       // sideband depth from classifier to divider output
  localparam int LAT  = CLAT + SBD + 1; // whole pipeline

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CROSS   = 2'd1,
    KIND_OVERLAP = 2'd2
  } contact_kind_e;

  typedef struct packed {
    logic signed [CW-1:0] seg1_start_x;
    logic signed [CW-1:0] seg1_start_y;
    logic signed [CW-1:0] seg1_end_x;
    logic signed [CW-1:0] seg1_end_y;
    logic signed [CW-1:0] seg2_start_x;
    logic signed [CW-1:0] seg2_start_y;
    logic signed [CW-1:0] seg2_end_x;
    logic signed [CW-1:0] seg2_end_y;
  } sip_req_t;

  typedef struct packed {
    contact_kind_e        contact_kind;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } sip_res_t;

  // Classifier outcome handed to the point calculation.
  typedef struct packed {
    contact_kind_e        kind;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic                 negx;
    logic                 negy;
    logic [MW-1:0]        mdx;
    logic [MW-1:0]        mdy;
    logic [NW-1:0]        num;
    logic [NW-1:0]        den;
  } sip_cls_t;

  typedef struct packed {
    contact_kind_e        kind;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic                 negx;
    logic                 negy;
  } sip_sb_t;

endpackage

/* rtl/sip_classify.sv */
// Four stage classifier: differences, products, cross products and contact decision.
`timescale 1ns / 1ps
module sip_classify import sip_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  sip_req_t req_i,
  output sip_cls_t cls_o
);

  function automatic logic in_box(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                  logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                                  logic signed [CW-1:0] rx, logic signed [CW-1:0] ry);
    logic okx;
    logic oky;
    okx = (px >= qx && px <= rx) || (px >= rx && px <= qx);
    oky = (py >= qy && py <= ry) || (py >= ry && py <= qy);
    return okx && oky;
  endfunction

  // Stage one.
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, wx_q, wy_q;
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic [3:0]           box1_q;
  // Stage two.
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [CW-1:0] ax2_q, ay2_q;
  logic [3:0]           box2_q;
  // Stage three.
  logic signed [XW-1:0] den_q, na_q, nb_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [CW-1:0] ax3_q, ay3_q;
  logic [3:0]           box3_q;

  logic signed [DW-1:0] magx_d, magy_d;
  logic signed [XW-1:0] dena_d, naa_d;
  logic                 neg_d, inr_d, ovl_d;
  contact_kind_e        kind_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax_q  <= DW'(req_i.seg1_end_x) - DW'(req_i.seg1_start_x);
      day_q  <= DW'(req_i.seg1_end_y) - DW'(req_i.seg1_start_y);
      dbx_q  <= DW'(req_i.seg2_end_x) - DW'(req_i.seg2_start_x);
      dby_q  <= DW'(req_i.seg2_end_y) - DW'(req_i.seg2_start_y);
      wx_q   <= DW'(req_i.seg2_start_x) - DW'(req_i.seg1_start_x);
      wy_q   <= DW'(req_i.seg2_start_y) - DW'(req_i.seg1_start_y);
      ax1_q  <= req_i.seg1_start_x;
      ay1_q  <= req_i.seg1_start_y;
      box1_q <= {in_box(req_i.seg2_start_x, req_i.seg2_start_y, req_i.seg1_start_x,
                        req_i.seg1_start_y, req_i.seg1_end_x, req_i.seg1_end_y),
                 in_box(req_i.seg2_end_x, req_i.seg2_end_y, req_i.seg1_start_x,
                        req_i.seg1_start_y, req_i.seg1_end_x, req_i.seg1_end_y),
                 in_box(req_i.seg1_start_x, req_i.seg1_start_y, req_i.seg2_start_x,
                        req_i.seg2_start_y, req_i.seg2_end_x, req_i.seg2_end_y),
                 in_box(req_i.seg1_end_x, req_i.seg1_end_y, req_i.seg2_start_x,
                        req_i.seg2_start_y, req_i.seg2_end_x, req_i.seg2_end_y)};

      p0_q   <= dax_q * dby_q;
      p1_q   <= day_q * dbx_q;
      p2_q   <= wx_q * dby_q;
      p3_q   <= wy_q * dbx_q;
      p4_q   <= wx_q * day_q;
      p5_q   <= wy_q * dax_q;
      dax2_q <= dax_q;
      day2_q <= day_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      box2_q <= box1_q;

      den_q  <= XW'(p0_q) - XW'(p1_q);
      na_q   <= XW'(p2_q) - XW'(p3_q);
      nb_q   <= XW'(p4_q) - XW'(p5_q);
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      box3_q <= box2_q;

      cls_o  <= '{kind: kind_d, ax: ax3_q, ay: ay3_q,
                  negx: dax3_q[DW-1], negy: day3_q[DW-1],
                  mdx: magx_d[MW-1:0], mdy: magy_d[MW-1:0],
                  num: naa_d[NW-1:0], den: dena_d[NW-1:0]};
    end
  end

  always_comb begin
    neg_d  = den_q[XW-1];
    magx_d = dax3_q[DW-1] ? -dax3_q : dax3_q;
    magy_d = day3_q[DW-1] ? -day3_q : day3_q;
    dena_d = neg_d ? -den_q : den_q;
    naa_d  = neg_d ? -na_q : na_q;
    // Both parameters inside [0, 1], tested on signs against the raw denominator.
    if (neg_d) begin
      inr_d = (na_q <= 0) && (nb_q <= 0) && (na_q >= den_q) && (nb_q >= den_q);
    end else begin
      inr_d = (na_q >= 0) && (nb_q >= 0) && (na_q <= den_q) && (nb_q <= den_q);
    end
    // On the common line the endpoints of the second segment lie on the first one's
    // line when nb is zero, and those of the first on the second's when na is zero.
    ovl_d = (nb_q == 0) && ((box3_q[3] || box3_q[2]) ||
                            ((na_q == 0) && (box3_q[1] || box3_q[0])));
    if (den_q == 0) begin
      kind_d = ovl_d ? KIND_OVERLAP : KIND_NONE;
    end else begin
      kind_d = inr_d ? KIND_CROSS : KIND_NONE;
    end
  end

endmodule

/* rtl/sip_div.sv */
// Pipelined restoring divider lane, one quotient bit per stage, rounded to nearest.
`timescale 1ns / 1ps
module sip_div import sip_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [QPW-1:0] dvd_i,
  input  logic [NW-1:0]  den_i,
  output logic [MW-1:0]  quo_o
);

  logic [NW-1:0] rem_q [MW+1];
  logic [MW-1:0] low_q [MW+1];
  logic [MW-1:0] quo_q [MW+1];
  logic [NW-1:0] den_q [MW+1];

  // The quotient stays below 2^MW, so the upper dividend bits start below den.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dvd_i[QPW-1:MW];
      low_q[0] <= dvd_i[MW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 0; k < MW; k++) begin : g_step
    logic [NW:0] trial;
    logic        ge;
    logic [NW:0] diff;
    always_comb begin
      trial = {rem_q[k], low_q[k][MW-1]};
      ge    = trial >= {1'b0, den_q[k]};
      diff  = trial - {1'b0, den_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[NW-1:0] : trial[NW-1:0];
        low_q[k+1] <= {low_q[k][MW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][MW-2:0], ge};
        den_q[k+1] <= den_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_q[MW] + MW'({rem_q[MW], 1'b0} >= {1'b0, den_q[MW]});
    end
  end

endmodule

/* rtl/segment_intersection_point.sv */
// Top level of the pipelined two dimensional segment intersection block.
`timescale 1ns / 1ps
// Each request carries two segments in signed Q16.8 and yields exactly one result: the
// contact kind (none or parallel, a single crossing, or collinear overlap) and, for a
// crossing, the crossing point rounded to nearest with halves away from the first
// segment's start. The block takes one request every cycle while the pipeline is not
// stalled, and holds no state between requests. A request passes through
// four classifier stages, two stages that scale the numerator, one stage for each of
// the 24 quotient bits of the two divider lanes plus their load and rounding stages,
// and an output register. The whole pipeline advances together; while a result waits
// at the output under stall, the input is stalled as well and nothing is lost.
module segment_intersection_point import sip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sip_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sip_res_t out_res_o
);

  logic           en;
  logic [LAT-1:0] vld_q;

  sip_cls_t       cls;
  sip_sb_t        sb_q [SBD];

  // Numerator scaling: two partial products per lane, then their sum.
  logic [MW+NLO-1:0] plx_q, ply_q;
  logic [MW+NHI-1:0] phx_q, phy_q;
  logic [NW-1:0]     den5_q, den6_q;
  logic [QPW-1:0]    dvdx_q, dvdy_q;
  logic [MW-1:0]     quox, quoy;

  // The pipeline moves unless a finished result is being held at the output.
  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  sip_classify u_classify (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (in_req_i),
    .cls_o (cls)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      plx_q  <= cls.mdx * cls.num[NLO-1:0];
      phx_q  <= cls.mdx * cls.num[NW-1:NLO];
      ply_q  <= cls.mdy * cls.num[NLO-1:0];
      phy_q  <= cls.mdy * cls.num[NW-1:NLO];
      den5_q <= cls.den;
      dvdx_q <= (QPW'(phx_q) << NLO) + QPW'(plx_q);
      dvdy_q <= (QPW'(phy_q) << NLO) + QPW'(ply_q);
      den6_q <= den5_q;
      sb_q[0] <= '{kind: cls.kind, ax: cls.ax, ay: cls.ay,
                   negx: cls.negx, negy: cls.negy};
    end
  end

  // Sideband line that keeps the start point and signs beside the divider lanes.
  for (genvar k = 1; k < SBD; k++) begin : g_sb
    always_ff @(posedge clk_i) begin
      if (en) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  sip_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .dvd_i (dvdx_q),
    .den_i (den6_q),
    .quo_o (quox)
  );

  sip_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .dvd_i (dvdy_q),
    .den_i (den6_q),
    .quo_o (quoy)
  );

  // The point lies between the first segment's endpoints, so the sum cannot wrap.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_res_o.contact_kind <= sb_q[SBD-1].kind;
      if (sb_q[SBD-1].kind == KIND_CROSS) begin
        out_res_o.cross_x <= sb_q[SBD-1].negx ? sb_q[SBD-1].ax - CW'(quox)
                                              : sb_q[SBD-1].ax + CW'(quox);
        out_res_o.cross_y <= sb_q[SBD-1].negy ? sb_q[SBD-1].ay - CW'(quoy)
                                              : sb_q[SBD-1].ay + CW'(quoy);
      end else begin
        out_res_o.cross_x <= '0;
        out_res_o.cross_y <= '0;
      end
    end
  end

endmodule
